// ===== rtl/ufcc_pkg.sv =====
// ----------------------------------------------------------------------------
// ufcc_pkg
// Shared widths and the result bundle of the union-find component counter.
// ----------------------------------------------------------------------------
package ufcc_pkg;

	localparam int NODE_W  = 10;
	localparam int COUNT_W = 11;

	// result of one union request, valid for one cycle
	typedef struct packed {
		logic              valid;
		logic              merged;
		logic [NODE_W-1:0] root;
	} resp_t;

endpackage

// ===== rtl/ufcc_ram.sv =====
// ----------------------------------------------------------------------------
// ufcc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ufcc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ufcc_engine.sv =====
// ----------------------------------------------------------------------------
// ufcc_engine
// Sequencer over the parent store: clearing sweep, root walk, path
// compression and link, with the live component count.
// ----------------------------------------------------------------------------
module ufcc_engine #(
	parameter int MAX_NODES = 1024,
	parameter int DEPTH     = 1024,
	parameter int CW        = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         init,
	input  logic [CW-1:0]                node_count,
	input  logic [CW-1:0]                cnt_init,
	input  logic                         start,
	input  logic [ufcc_pkg::NODE_W-1:0]  node_a,
	input  logic [ufcc_pkg::NODE_W-1:0]  node_b,
	output logic                         busy,
	output ufcc_pkg::resp_t              resp,
	output logic [CW-1:0]                comp_cnt
);
	import ufcc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int XW = (CW > NODE_W) ? CW : NODE_W;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_RD    = 5'b00100,
		S_CHK   = 5'b01000,
		S_LINK  = 5'b10000
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   cur_q;
	logic [AW-1:0]   orig_q;
	logic [AW-1:0]   root_q;
	logic [AW-1:0]   ra_q;
	logic [AW-1:0]   b_q;
	logic            find_q;
	logic            side_q;
	logic [CW-1:0]   comp_q;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   wdata;
	logic [AW-1:0]   rdata;
	logic            in_range;
	logic            node_done;
	logic [AW-1:0]   r_found;

	ufcc_ram #(
		.WIDTH (AW),
		.DEPTH (DEPTH)
	) u_parent (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (cur_q),
		.rdata (rdata)
	);

	assign in_range = (XW'(node_a) < XW'(node_count)) && (XW'(node_b) < XW'(node_count));
	assign busy     = (state_q != S_IDLE);
	assign comp_cnt = comp_q;
	assign r_found  = find_q ? cur_q : root_q;
	// walk of the current node is over: root reached with nothing to compress,
	// or the compression has arrived at the root
	assign node_done = find_q ? ((rdata == cur_q) && (orig_q == cur_q)) : (rdata == root_q);

	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = root_q;
		resp  = '0;
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = clr_q;
			end
			S_IDLE: begin
				if (start && !in_range) begin
					resp.valid = 1'b1;
				end
			end
			S_RD: begin
			end
			S_CHK: begin
				// point the path node straight at its root
				we = !find_q;
			end
			S_LINK: begin
				resp.valid = 1'b1;
				resp.root  = NODE_W'(root_q);
				if (ra_q != root_q) begin
					we          = 1'b1;
					waddr       = ra_q;
					resp.merged = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			comp_q  <= CW'(MAX_NODES);
			find_q  <= 1'b0;
			side_q  <= 1'b0;
		end else if (init) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			comp_q  <= cnt_init;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start && in_range) begin
						cur_q   <= node_a[AW-1:0];
						orig_q  <= node_a[AW-1:0];
						b_q     <= node_b[AW-1:0];
						find_q  <= 1'b1;
						side_q  <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (node_done) begin
						root_q <= r_found;
						if (!side_q) begin
							// advance to the second node
							ra_q    <= r_found;
							side_q  <= 1'b1;
							find_q  <= 1'b1;
							cur_q   <= b_q;
							orig_q  <= b_q;
							state_q <= S_RD;
						end else begin
							state_q <= S_LINK;
						end
					end else if (find_q && (rdata == cur_q)) begin
						// root found: restart at the origin to compress
						root_q  <= cur_q;
						find_q  <= 1'b0;
						cur_q   <= orig_q;
						state_q <= S_RD;
					end else begin
						cur_q   <= rdata;
						state_q <= S_RD;
					end
				end
				S_LINK: begin
					if ((ra_q != root_q) && (comp_q > CW'(1))) begin
						comp_q <= comp_q - 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		comp_q != '0)
		else $error("component count reached zero");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !resp.valid)
		else $error("result issued during clearing sweep");

	a_merge_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(resp.valid && resp.merged && !init) |=>
			(comp_q == $past(comp_q) - CW'(1)) || ($past(comp_q) == CW'(1)))
		else $error("merge did not drop the component count");

	a_compress_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK && !find_q) |-> (cur_q != root_q))
		else $error("compression wrote the root itself");

endmodule

// ===== rtl/union_find_component_counter.sv =====
// ----------------------------------------------------------------------------
// union_find_component_counter
// Disjoint-set union engine with path compression and a live component count.
//
//  port group                    dir  handshake
//  start, node_a, node_b         in   taken when start && !busy
//  done, merged, root,           out  done strobe, one cycle, no back-pressure
//    components
//  cfg_valid, cfg_data           in   beat when cfg_valid && cfg_ready
//
// Every parent read passes a read state and a check state: for a node at depth d
// the walk reads d+1 entries and compression rewrites d of them; a link state
// ends the item. An out-of-range request is answered from idle without a walk.
// The single read port of the parent store paces the walk.
// After reset and after every node_count write a clearing sweep over all
// min(MAX_NODES, 1024) entries of the parent store runs with busy high.
// Results cannot be stalled; components holds the count after the last item.
// ----------------------------------------------------------------------------
module union_find_component_counter #(
	parameter int MAX_NODES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ufcc_pkg::NODE_W-1:0]   node_a,
	input  logic [ufcc_pkg::NODE_W-1:0]   node_b,
	output logic                          busy,
	output logic                          done,
	output logic                          merged,
	output logic [ufcc_pkg::NODE_W-1:0]   root,
	output logic [ufcc_pkg::COUNT_W-1:0]  components,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ufcc_pkg::COUNT_W-1:0]  cfg_data
);
	import ufcc_pkg::*;

	localparam int DEPTH = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
	localparam int CW    = $clog2(MAX_NODES + 1);
	localparam int XW    = (CW > COUNT_W) ? CW : COUNT_W;

	logic [CW-1:0]      node_count_q;
	logic [CW-1:0]      cnt_init;
	logic [COUNT_W-1:0] cfg_nz;
	logic               init;
	logic [CW-1:0]      comp_cnt;
	resp_t              resp;
	logic               done_q;
	logic               merged_q;
	logic [NODE_W-1:0]  root_q;

	assign cfg_ready = 1'b1;
	assign init      = cfg_valid && cfg_ready;

	// zero reads as one, anything past MAX_NODES saturates
	assign cfg_nz   = (cfg_data == '0) ? COUNT_W'(1) : cfg_data;
	assign cnt_init = (XW'(cfg_nz) > XW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(cfg_nz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CW'(MAX_NODES);
			done_q       <= 1'b0;
		end else begin
			if (init) begin
				node_count_q <= cnt_init;
			end
			done_q <= resp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (resp.valid) begin
			merged_q <= resp.merged;
			root_q   <= resp.root;
		end
	end

	ufcc_engine #(
		.MAX_NODES (MAX_NODES),
		.DEPTH     (DEPTH),
		.CW        (CW)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.init       (init),
		.node_count (node_count_q),
		.cnt_init   (cnt_init),
		.start      (start),
		.node_a     (node_a),
		.node_b     (node_b),
		.busy       (busy),
		.resp       (resp),
		.comp_cnt   (comp_cnt)
	);

	assign done       = done_q;
	assign merged     = merged_q;
	assign root       = root_q;
	assign components = COUNT_W'(comp_cnt);

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the union-find component counter.
// Union requests come from a queue: a directed opening, then random phases
// over several node counts, among them a long chain that forces deep walks.
// A behavioural disjoint-set model predicts every result. The monitor checks
// merged, root and components against it.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ufcc_pkg::*;

	localparam int MAX_NODES      = 1024;
	localparam int PHASE_ITEMS    = 168;
	localparam int N_PHASES       = 11;
	localparam int CHAIN_PHASE    = 2;
	localparam int QUIET_CYCLES   = 4;
	localparam int TAIL_CYCLES    = 20;
	localparam int STALL_LIMIT    = 40000;

	typedef enum logic [1:0] {ENTRY_UNION, ENTRY_CONFIG, ENTRY_DRAIN} entry_kind_t;
	typedef enum logic [4:0] {
		DRV_NEXT  = 5'b00001,
		DRV_QUIET = 5'b00010,
		DRV_GAP   = 5'b00100,
		DRV_HOLD  = 5'b01000,
		DRV_END   = 5'b10000
	} drv_phase_t;

	typedef struct {
		entry_kind_t        kind;
		logic [NODE_W-1:0]  a;
		logic [NODE_W-1:0]  b;
		logic [COUNT_W-1:0] value;
		int unsigned        gap;
	} bench_entry_t;

	typedef struct packed {
		logic               merged;
		logic [NODE_W-1:0]  root;
		logic [COUNT_W-1:0] components;
	} union_result_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	logic [NODE_W-1:0]  node_a    = '0;
	logic [NODE_W-1:0]  node_b    = '0;
	logic               cfg_valid = 1'b0;
	logic [COUNT_W-1:0] cfg_data  = '0;
	logic               busy;
	logic               done;
	logic               merged;
	logic [NODE_W-1:0]  root;
	logic [COUNT_W-1:0] components;
	logic               cfg_ready;

	union_find_component_counter #(.MAX_NODES(MAX_NODES)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.node_a     (node_a),
		.node_b     (node_b),
		.busy       (busy),
		.done       (done),
		.merged     (merged),
		.root       (root),
		.components (components),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// disjoint-set model
	logic [NODE_W-1:0] set_parent [0:MAX_NODES-1];
	int unsigned       live_sets;
	int unsigned       nodes_in_use;

	bench_entry_t      pending_work [$];
	union_result_t     expected_results [$];

	int unsigned error_count  = 0;
	int unsigned union_count  = 0;
	int unsigned merge_count  = 0;
	int unsigned joint_count  = 0;
	int unsigned ignore_count = 0;
	int unsigned write_count  = 0;
	int unsigned result_count = 0;
	bit          stim_done    = 1'b0;
	bit          gapless      = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_sets(input int unsigned count);
		for (int i = 0; i < MAX_NODES; i++)
			set_parent[i] = NODE_W'(i);
		nodes_in_use = count;
		live_sets    = count;
	endfunction

	function automatic void apply_node_count(input logic [COUNT_W-1:0] value);
		int unsigned count;
		count = value;
		if (count == 0)
			count = 1;
		if (count > MAX_NODES)
			count = MAX_NODES;
		write_count++;
		clear_sets(count);
	endfunction

	// walk to the root, then point every visited node straight at it
	function automatic logic [NODE_W-1:0] find_and_flatten(input logic [NODE_W-1:0] v);
		logic [NODE_W-1:0] top;
		logic [NODE_W-1:0] cur;
		logic [NODE_W-1:0] nxt;
		top = v;
		while (set_parent[top] != top)
			top = set_parent[top];
		cur = v;
		while (cur != top) begin
			nxt = set_parent[cur];
			set_parent[cur] = top;
			cur = nxt;
		end
		return top;
	endfunction

	function automatic void predict_union(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
		union_result_t     res;
		logic [NODE_W-1:0] top_a;
		logic [NODE_W-1:0] top_b;
		res.merged = 1'b0;
		res.root   = '0;
		union_count++;
		if (a < nodes_in_use && b < nodes_in_use) begin
			top_a    = find_and_flatten(a);
			top_b    = find_and_flatten(b);
			res.root = top_b;
			if (top_a != top_b) begin
				set_parent[top_a] = top_b;
				if (live_sets > 1)
					live_sets--;
				res.merged = 1'b1;
				merge_count++;
			end else begin
				joint_count++;
			end
		end else begin
			ignore_count++;
		end
		res.components = COUNT_W'(live_sets);
		expected_results.push_back(res);
	endfunction

	task automatic flag_error(input string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		error_count++;
	endtask

	function automatic int unsigned draw_gap();
		return gapless ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic void add_union(input int unsigned a, input int unsigned b);
		bench_entry_t e;
		e.kind  = ENTRY_UNION;
		e.a     = NODE_W'(a);
		e.b     = NODE_W'(b);
		e.value = '0;
		e.gap   = draw_gap();
		pending_work.push_back(e);
	endfunction

	function automatic void add_config(input int unsigned value);
		bench_entry_t e;
		e.kind  = ENTRY_CONFIG;
		e.a     = '0;
		e.b     = '0;
		e.value = COUNT_W'(value);
		e.gap   = draw_gap();
		pending_work.push_back(e);
	endfunction

	function automatic void add_drain();
		bench_entry_t e;
		e.kind  = ENTRY_DRAIN;
		e.a     = '0;
		e.b     = '0;
		e.value = '0;
		e.gap   = 0;
		pending_work.push_back(e);
	endfunction

	// half the picks come from a window of 32 nodes so that sets collide
	function automatic int unsigned pick_in(input int unsigned count, input int unsigned anchor);
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, count - 1);
		return (anchor + $urandom_range(0, 31)) % count;
	endfunction

	// stimulus
	initial begin : stimulus
		int unsigned phase_values [N_PHASES];
		int unsigned count;
		int unsigned anchor;
		int unsigned made;
		int unsigned a;
		int unsigned b;
		phase_values = '{1024, 16, 64, 2, 300, 2047, 1000, 3, 512, 1, 1025};

		// extremes and same-set cases at the reset node count
		add_union(0, 1023);
		add_union(1023, 0);
		add_union(0, 0);
		add_union(682, 341);
		add_union(341, 1023);
		add_union(1023, 1023);
		// a zero write leaves a single node
		add_config(0);
		add_union(0, 0);
		add_union(0, 1);
		add_union(1023, 0);
		add_union(1023, 1023);
		// out of range on either side, then merge down to one set
		add_config(5);
		add_union(2, 7);
		add_union(5, 0);
		add_union(0, 1);
		add_union(1, 2);
		add_union(2, 3);
		add_union(3, 4);
		add_union(0, 4);
		add_union(4, 4);
		add_config(1000);
		add_union(999, 1000);
		add_union(1000, 999);
		add_union(999, 0);

		for (int p = 0; p < N_PHASES; p++) begin
			add_config(phase_values[p]);
			count = phase_values[p];
			if (count > MAX_NODES)
				count = MAX_NODES;
			anchor = $urandom_range(0, count - 1);
			made = 0;
			if (p == CHAIN_PHASE) begin
				// link each root under the next: node 0 ends up deepest
				for (int i = 0; i + 1 < count; i++)
					add_union(i, i + 1);
				add_union(0, count - 1);
				made = count;
			end
			while (made < PHASE_ITEMS) begin
				if (made % 40 == 0)
					gapless = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 59) == 0)
					add_drain();
				if (count < MAX_NODES && $urandom_range(0, 9) == 0) begin
					a = pick_in(count, anchor);
					b = pick_in(count, anchor);
					case ($urandom_range(0, 2))
						0: a = $urandom_range(count, MAX_NODES - 1);
						1: b = $urandom_range(count, MAX_NODES - 1);
						default: begin
							a = $urandom_range(count, MAX_NODES - 1);
							b = $urandom_range(count, MAX_NODES - 1);
						end
					endcase
				end else begin
					a = pick_in(count, anchor);
					b = pick_in(count, anchor);
				end
				add_union(a, b);
				made++;
			end
		end
		add_drain();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (stim_done && expected_results.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d union requests: %0d merges, %0d already joined, %0d ignored",
			union_count, merge_count, joint_count, ignore_count);
		$display("%0d node count writes, %0d results checked", write_count, result_count);
		if (error_count == 0) begin
			$display("[union_find_component_counter] OK");
		end else begin
			$display("[union_find_component_counter] ERROR");
		end
		$finish;
	end

	// driver
	bench_entry_t cur_entry;
	drv_phase_t   drv_phase  = DRV_NEXT;
	int unsigned  wait_left  = 0;
	int unsigned  quiet_left = 0;

	always @(posedge clk or negedge arst_n) begin : driver
		logic nx_start;
		logic nx_cfg_valid;
		if (!arst_n) begin
			start     <= 1'b0;
			node_a    <= '0;
			node_b    <= '0;
			cfg_valid <= 1'b0;
			cfg_data  <= '0;
			drv_phase = DRV_NEXT;
			clear_sets(MAX_NODES);
		end else begin
			nx_start     = start;
			nx_cfg_valid = cfg_valid;
			if (start && !busy) begin
				predict_union(node_a, node_b);
				nx_start  = 1'b0;
				drv_phase = DRV_NEXT;
			end
			if (cfg_valid && cfg_ready) begin
				apply_node_count(cfg_data);
				nx_cfg_valid = 1'b0;
				drv_phase    = DRV_NEXT;
			end
			if (drv_phase == DRV_NEXT) begin
				if (pending_work.size() == 0) begin
					stim_done = 1'b1;
					drv_phase = DRV_END;
				end else begin
					cur_entry  = pending_work.pop_front();
					wait_left  = cur_entry.gap;
					quiet_left = QUIET_CYCLES;
					drv_phase  = (cur_entry.kind == ENTRY_UNION) ? DRV_GAP : DRV_QUIET;
				end
			end
			// hold until every result is back and the block is idle
			if (drv_phase == DRV_QUIET) begin
				if (expected_results.size() != 0 || busy)
					quiet_left = QUIET_CYCLES;
				else if (quiet_left != 0)
					quiet_left--;
				else if (cur_entry.kind == ENTRY_DRAIN)
					drv_phase = DRV_NEXT;
				else
					drv_phase = DRV_GAP;
			end
			if (drv_phase == DRV_GAP) begin
				if (wait_left != 0) begin
					wait_left--;
				end else begin
					if (cur_entry.kind == ENTRY_UNION) begin
						nx_start = 1'b1;
						node_a   <= cur_entry.a;
						node_b   <= cur_entry.b;
					end else begin
						nx_cfg_valid = 1'b1;
						cfg_data     <= cur_entry.value;
					end
					drv_phase = DRV_HOLD;
				end
			end
			start     <= nx_start;
			cfg_valid <= nx_cfg_valid;
		end
	end

	// monitor
	always @(posedge clk) begin : result_check
		union_result_t want;
		if (arst_n && done) begin
			result_count++;
			if (expected_results.size() == 0) begin
				flag_error($sformatf("result with nothing outstanding (root %0d)", root));
			end else begin
				want = expected_results.pop_front();
				if (merged !== want.merged)
					flag_error($sformatf("merged %0b, want %0b", merged, want.merged));
				if (root !== want.root)
					flag_error($sformatf("root %0d, want %0d", root, want.root));
				if (components !== want.components)
					flag_error($sformatf("components %0d, want %0d",
						components, want.components));
			end
		end
	end

	// watchdog: count cycles without any beat
	int unsigned stall_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without a beat", stall_cycles);
				$display("[union_find_component_counter] ERROR");
				$finish;
			end
		end
	end

endmodule

// ===== union_find_component_counter.f =====
rtl/ufcc_pkg.sv
rtl/ufcc_ram.sv
rtl/ufcc_engine.sv
rtl/union_find_component_counter.sv
bench/tb_top.sv
